// ===== rtl/stsm_pkg.sv =====
// Shared constants for the segment tree range-sum block.
// No dependencies; used by segment_tree_range_sum_mod and stsm_alu.
`default_nettype none

package stsm_pkg;

  localparam int LEAVES_DEF = 1024;

  localparam int VAL_W  = 30;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;
  localparam int IDX_W  = 11;

  localparam logic [VAL_W-1:0]  MODULUS  = 30'd998244353;
  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1024;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/segment_tree_range_sum_mod.sv =====
// Segment tree, point write and modular range sum, one item at a time.
// Write: stores the reduced leaf, then one tree level a cycle up to the root, then the result beat.
// Query: one RAM read port, up to two node reads a level.
// After rst_n the tree RAM is cleared, one node a cycle, with in_tready low.
// Config beats are taken at any time; size register resets to 1024.
// Depends on stsm_pkg, stsm_ram, stsm_alu.
`default_nettype none

module segment_tree_range_sum_mod #(
  parameter int LEAVES = stsm_pkg::LEAVES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // position[9:0], value[39:10], left[50:40], right[61:51], zero pad
  input  wire logic [63:0]                in_tdata,
  // action[0]
  input  wire logic [0:0]                 in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // total[29:0], zero pad
  output logic      [31:0]                out_tdata,
  // error[0]
  output logic      [0:0]                 out_tuser,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [stsm_pkg::SIZE_W-1:0] cfg_data
);

  localparam int VW    = stsm_pkg::VAL_W;
  localparam int DEPTH = 2 * LEAVES;
  localparam int NW    = $clog2(DEPTH);
  localparam int QW    = NW + 1;
  localparam int CW    = (NW > stsm_pkg::IDX_W) ? NW : stsm_pkg::IDX_W;
  localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);
  localparam logic [NW-1:0] ROOT      = NW'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_W_LEAF,
    S_W_ADD,
    S_Q_LO,
    S_Q_HI,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NW-1:0]            node_r, node_nxt;
  logic [NW-1:0]            clr_r, clr_nxt;
  logic [VW-1:0]            cur_r, cur_nxt;
  logic [VW-1:0]            acc_r, acc_nxt;
  logic [QW-1:0]            lo_r, lo_nxt;
  logic [QW-1:0]            hi_r, hi_nxt;
  logic                     pend_r, pend_nxt;
  logic                     err_r, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [VW-1:0]            out_total_r, out_total_nxt;
  logic                     out_error_r, out_error_nxt;
  logic [stsm_pkg::SIZE_W-1:0] size_r;

  logic [stsm_pkg::POS_W-1:0] in_pos;
  logic [VW-1:0]              in_value;
  logic [stsm_pkg::IDX_W-1:0] in_left;
  logic [stsm_pkg::IDX_W-1:0] in_right;

  logic [CW-1:0] size_ext;
  logic [CW-1:0] leaves_c;
  logic [CW-1:0] bound;
  logic          wr_err;
  logic          q_err;
  logic [NW-1:0] leaf_node;
  logic [CW:0]   lo_sum;
  logic [CW:0]   hi_sum;
  logic [NW-1:0] node_up;

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic [NW-1:0] mem_raddr;
  logic [VW-1:0] mem_rdata;

  logic [VW-1:0] alu_a;
  logic [VW-1:0] alu_b;
  logic [VW-1:0] alu_y;

  assign in_pos   = in_tdata[9:0];
  assign in_value = in_tdata[39:10];
  assign in_left  = in_tdata[50:40];
  assign in_right = in_tdata[61:51];

  assign size_ext  = CW'(size_r);
  assign leaves_c  = CW'(LEAVES);
  assign bound     = (size_ext < leaves_c) ? size_ext : leaves_c;
  assign wr_err    = CW'(in_pos) >= bound;
  assign q_err     = (in_left > in_right) || (CW'(in_right) > bound);
  assign leaf_node = NW'(CW'(in_pos) + leaves_c);
  assign lo_sum    = (CW+1)'(in_left) + (CW+1)'(LEAVES);
  assign hi_sum    = (CW+1)'(in_right) + (CW+1)'(LEAVES);
  assign node_up   = node_r >> 1;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_total_r};
  assign out_tuser  = out_error_r;

  stsm_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  stsm_alu u_alu (
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_total_nxt = out_total_r;
    out_error_nxt = out_error_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = alu_y;
    mem_raddr     = NW'(lo_r);
    alu_a         = cur_r;
    alu_b         = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          acc_nxt  = '0;
          pend_nxt = 1'b0;
          err_nxt  = 1'b0;
          node_nxt = leaf_node;
          cur_nxt  = in_value;
          lo_nxt   = QW'(lo_sum);
          hi_nxt   = QW'(hi_sum);
          if (in_tuser[0] == stsm_pkg::ACT_WRITE) begin
            if (wr_err) begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_W_LEAF;
            end
          end else begin
            if (q_err) begin
              err_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_Q_LO;
            end
          end
        end
      end
      S_W_LEAF: begin
        // alu with b = 0 reduces the raw value
        mem_we    = 1'b1;
        mem_waddr = node_r;
        cur_nxt   = alu_y;
        mem_raddr = node_r ^ ROOT;
        state_nxt = S_W_ADD;
      end
      S_W_ADD: begin
        alu_b     = mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = node_up;
        cur_nxt   = alu_y;
        node_nxt  = node_up;
        mem_raddr = node_up ^ ROOT;
        if (node_up == ROOT) begin
          state_nxt = S_DONE;
        end
      end
      S_Q_LO: begin
        alu_a = acc_r;
        alu_b = mem_rdata;
        if (pend_r) begin
          acc_nxt = alu_y;
        end
        if (lo_r >= hi_r) begin
          state_nxt = S_DONE;
        end else begin
          if (lo_r[0]) begin
            mem_raddr = NW'(lo_r);
            lo_nxt    = lo_r + 1'b1;
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
          state_nxt = S_Q_HI;
        end
      end
      S_Q_HI: begin
        alu_a = acc_r;
        alu_b = mem_rdata;
        if (pend_r) begin
          acc_nxt = alu_y;
        end
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
        if (hi_r[0]) begin
          mem_raddr = NW'(hi_r - 1'b1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        state_nxt = S_Q_LO;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
          out_error_nxt = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      size_r      <= stsm_pkg::SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
    end
    node_r      <= node_nxt;
    cur_r       <= cur_nxt;
    acc_r       <= acc_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    pend_r      <= pend_nxt;
    err_r       <= err_nxt;
    out_total_r <= out_total_nxt;
    out_error_r <= out_error_nxt;
  end

  a_err_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error beat carries a nonzero total");

  a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VW-1:0] < stsm_pkg::MODULUS)
    else $error("total not reduced");

  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_LO || state_r == S_Q_HI) |-> !mem_we)
    else $error("tree written during a query");

  a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_Q_HI |-> lo_r <= hi_r)
    else $error("query edges crossed");

  a_leaf_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W_LEAF |-> mem_we && mem_wdata < stsm_pkg::MODULUS)
    else $error("leaf stored unreduced");

endmodule

`default_nettype wire

// ===== rtl/stsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stsm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/stsm_alu.sv =====
// Shared modular adder: (a + b) mod 998244353, correct while a + b is below 2 * 998244353.
// Depends on stsm_pkg.
`default_nettype none

module stsm_alu (
  input  wire logic [stsm_pkg::VAL_W-1:0] a,
  input  wire logic [stsm_pkg::VAL_W-1:0] b,
  output logic      [stsm_pkg::VAL_W-1:0] y
);

  logic [stsm_pkg::VAL_W:0] sum;
  logic [stsm_pkg::VAL_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = sum - {1'b0, stsm_pkg::MODULUS};
  assign y    = (sum >= {1'b0, stsm_pkg::MODULUS}) ? diff[stsm_pkg::VAL_W-1:0]
                                                    : sum[stsm_pkg::VAL_W-1:0];

endmodule

`default_nettype wire
